// File: hw/rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants of the audio level meter
// Averaging weights, register indexes, reset values and control struct.
// ----------------------------------------------------------------------------
package alm_pkg;

    localparam int LEVEL_W = 16;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 16;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd32768;

    // Q0.16 weights of the new sample
    localparam int W_TENTH      = 6554;
    localparam int W_HUNDREDTH  = 655;
    localparam int W_THOUSANDTH = 66;

    localparam logic [CFG_W-1:0] RST_CLIP_THRESHOLD = 16'd32440;
    localparam logic [CFG_W-1:0] RST_CLIP_HOLD_MS   = 16'd1000;
    localparam logic [CFG_W-1:0] RST_PEAK_DECAY     = 16'd65208;

    typedef enum logic [1:0] {
        CFG_CLIP_THRESHOLD = 2'd0,
        CFG_CLIP_HOLD_MS   = 2'd1,
        CFG_PEAK_DECAY     = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req;

    typedef struct packed {
        logic sample;
        logic clear;
    } t_upd_ctl;

endpackage

// File: hw/rtl/alm_avg.sv
// ----------------------------------------------------------------------------
// alm_avg: first-order running average
// Holds one accumulator and blends in each new value with a fixed weight,
// rounding half up.
// ----------------------------------------------------------------------------
module alm_avg #(
    parameter int EXTRA_FRAC_BITS = 16,
    parameter int WEIGHT          = 6554,
    parameter bit SIGNED_IN       = 1'b0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [alm_pkg::LEVEL_W-1:0] i_x,
    output logic [alm_pkg::LEVEL_W-1:0] o_level_next
);
    import alm_pkg::*;

    localparam int ACC_W = LEVEL_W + EXTRA_FRAC_BITS;
    localparam int P_W   = ACC_W + 19;
    localparam int OLD_W = 65536 - WEIGHT;

    logic        [ACC_W-1:0] r_acc;
    logic        [ACC_W-1:0] n_acc;
    logic signed [ACC_W:0]   acc_s;
    logic signed [LEVEL_W:0] x_s;
    logic signed [17:0]      c_old;
    logic signed [17:0]      c_new;
    logic signed [P_W-1:0]   prod_old;
    logic signed [P_W-1:0]   prod_new;
    logic signed [P_W-1:0]   sum;

    assign c_old = 18'(OLD_W);
    assign c_new = 18'(WEIGHT);
    assign acc_s = SIGNED_IN ? {r_acc[ACC_W-1], r_acc} : {1'b0, r_acc};
    assign x_s   = SIGNED_IN ? {i_x[LEVEL_W-1], i_x} : {1'b0, i_x};

    always_comb begin
        prod_old = acc_s * c_old;
        prod_new = x_s * c_new;
        sum      = prod_old + (prod_new <<< EXTRA_FRAC_BITS) + $signed(P_W'(32768));
        n_acc    = ACC_W'(sum >>> 16);
    end

    assign o_level_next = i_en ? n_acc[ACC_W-1:EXTRA_FRAC_BITS]
                               : r_acc[ACC_W-1:EXTRA_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

endmodule

// File: hw/rtl/alm_peak_clip.sv
// ----------------------------------------------------------------------------
// alm_peak_clip: decaying peak and clip indication
// Tracks the peak with per-item decay, the held clip flag, the saturating
// clip count and the time of the last clip.
// ----------------------------------------------------------------------------
module alm_peak_clip #(
    parameter int EXTRA_FRAC_BITS = 16,
    parameter int TIME_BITS       = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  alm_pkg::t_upd_ctl           i_ctl,
    input  logic [alm_pkg::LEVEL_W-1:0] i_lvl,
    input  logic [TIME_BITS-1:0]        i_time,
    input  logic [alm_pkg::CFG_W-1:0]   i_threshold,
    input  logic [alm_pkg::CFG_W-1:0]   i_hold_ms,
    input  logic [alm_pkg::CFG_W-1:0]   i_decay,
    output logic [alm_pkg::LEVEL_W-1:0] o_peak_next,
    output logic                        o_clip_next,
    output logic [alm_pkg::COUNT_W-1:0] o_total_next
);
    import alm_pkg::*;

    localparam int ACC_W = LEVEL_W + EXTRA_FRAC_BITS;

    logic [ACC_W-1:0]     r_peak;
    logic [ACC_W-1:0]     n_peak;
    logic                 r_clip;
    logic                 n_clip;
    logic [COUNT_W-1:0]   r_total;
    logic [COUNT_W-1:0]   n_total;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] n_last;
    logic [ACC_W+15:0]    prod;
    logic [ACC_W-1:0]     decayed;
    logic [ACC_W-1:0]     lvl_acc;
    logic [TIME_BITS-1:0] dt;
    logic                 hit;

    always_comb begin
        prod    = (ACC_W + 16)'(r_peak) * (ACC_W + 16)'(i_decay);
        decayed = prod[ACC_W+15:16];
        lvl_acc = {i_lvl, {EXTRA_FRAC_BITS{1'b0}}};
        dt      = i_time - r_last;
        hit     = (i_lvl >= i_threshold);

        n_peak  = r_peak;
        n_clip  = r_clip;
        n_total = r_total;
        n_last  = r_last;
        if (i_ctl.clear) begin
            n_peak  = '0;
            n_clip  = 1'b0;
            n_total = '0;
        end else if (i_ctl.sample) begin
            n_peak = (decayed < lvl_acc) ? lvl_acc : decayed;
            if (hit) begin
                n_clip = 1'b1;
                n_last = i_time;
                if (r_total != '1) begin
                    n_total = r_total + 1'b1;
                end
            end else if (r_clip && (dt > TIME_BITS'(i_hold_ms))) begin
                n_clip = 1'b0;
            end
        end
    end

    assign o_peak_next  = n_peak[ACC_W-1:EXTRA_FRAC_BITS];
    assign o_clip_next  = n_clip;
    assign o_total_next = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_clip  <= 1'b0;
            r_total <= '0;
            r_last  <= '0;
        end else begin
            r_peak  <= n_peak;
            r_clip  <= n_clip;
            r_total <= n_total;
            r_last  <= n_last;
        end
    end

endmodule

// File: hw/rtl/audio_level_meter.sv
// ----------------------------------------------------------------------------
// audio_level_meter: VU, peak, clip, noise, DC and load meter
//
//  channel  direction  tdata fields (lsb first)                       tuser
//  s_axis   in         abs_level, quant_err, dc_sample, load_sample,  req_type
//                      time_ms
//  m_axis   out        vu_out, peak_out, clip_flag, clip_total,       -
//                      noise_out, dc_out, load_out
//  cfg      in         write enable, register index, 16-bit data      -
//
// One item per cycle unless the result stalls; an accepted item goes through the
// input register, then one constant-weight multiply-add per average, into the
// result register. Synchronous active-low reset clears all averages, the peak,
// the clip state and both valid flags; no clearing pass. A stalled result
// holds its register while one more item waits in the input register.
// ----------------------------------------------------------------------------
module audio_level_meter #(
    parameter int EXTRA_FRAC_BITS = 16,
    parameter int TIME_BITS       = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // abs_level[15:0], quant_err[31:16], dc_sample[47:32], load_sample[63:48],
    // time_ms[95:64]
    input  logic [95:0]  s_axis_tdata,
    // req_type[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vu_out[15:0], peak_out[31:16], clip_flag[32], clip_total[64:33],
    // noise_out[80:65], dc_out[96:81], load_out[112:97], zero[119:113]
    output logic [119:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import alm_pkg::*;

    logic                 r_in_valid;
    logic                 r_req;
    logic [LEVEL_W-1:0]   r_abs;
    logic [LEVEL_W-1:0]   r_qe;
    logic [LEVEL_W-1:0]   r_dc;
    logic [LEVEL_W-1:0]   r_load;
    logic [31:0]          r_time;

    logic [CFG_W-1:0]     r_threshold;
    logic [CFG_W-1:0]     r_hold_ms;
    logic [CFG_W-1:0]     r_decay;

    logic                 r_out_valid;
    logic [119:0]         r_out_data;

    logic                 advance;
    t_upd_ctl             ctl;
    logic [LEVEL_W-1:0]   lvl;
    logic [LEVEL_W-1:0]   ld;
    logic [LEVEL_W-1:0]   qmag;
    logic [TIME_BITS-1:0] t_now;
    logic [LEVEL_W-1:0]   vu_next;
    logic [LEVEL_W-1:0]   noise_next;
    logic [LEVEL_W-1:0]   dc_next;
    logic [LEVEL_W-1:0]   load_next;
    logic [LEVEL_W-1:0]   peak_next;
    logic                 clip_next;
    logic [COUNT_W-1:0]   total_next;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        ctl.sample = advance && (r_req == REQ_SAMPLE);
        ctl.clear  = advance && (r_req == REQ_CLEAR);
        lvl        = (r_abs > FULL_SCALE) ? FULL_SCALE : r_abs;
        ld         = (r_load > FULL_SCALE) ? FULL_SCALE : r_load;
        qmag       = r_qe[LEVEL_W-1] ? LEVEL_W'(-r_qe) : r_qe;
        t_now      = TIME_BITS'(r_time);
    end

    alm_avg #(
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .WEIGHT          (W_TENTH),
        .SIGNED_IN       (1'b0)
    ) u_vu (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (ctl.sample),
        .i_x          (lvl),
        .o_level_next (vu_next)
    );

    alm_avg #(
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .WEIGHT          (W_HUNDREDTH),
        .SIGNED_IN       (1'b0)
    ) u_noise (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (ctl.sample),
        .i_x          (qmag),
        .o_level_next (noise_next)
    );

    alm_avg #(
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .WEIGHT          (W_THOUSANDTH),
        .SIGNED_IN       (1'b1)
    ) u_dc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (ctl.sample),
        .i_x          (r_dc),
        .o_level_next (dc_next)
    );

    alm_avg #(
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .WEIGHT          (W_TENTH),
        .SIGNED_IN       (1'b0)
    ) u_load (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (ctl.sample),
        .i_x          (ld),
        .o_level_next (load_next)
    );

    alm_peak_clip #(
        .EXTRA_FRAC_BITS (EXTRA_FRAC_BITS),
        .TIME_BITS       (TIME_BITS)
    ) u_peak_clip (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_lvl        (lvl),
        .i_time       (t_now),
        .i_threshold  (r_threshold),
        .i_hold_ms    (r_hold_ms),
        .i_decay      (r_decay),
        .o_peak_next  (peak_next),
        .o_clip_next  (clip_next),
        .o_total_next (total_next)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_CLIP_THRESHOLD;
            r_hold_ms   <= RST_CLIP_HOLD_MS;
            r_decay     <= RST_PEAK_DECAY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CLIP_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_CLIP_HOLD_MS:   r_hold_ms   <= i_cfg_data;
                CFG_PEAK_DECAY:     r_decay     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_req  <= s_axis_tuser;
            r_abs  <= s_axis_tdata[15:0];
            r_qe   <= s_axis_tdata[31:16];
            r_dc   <= s_axis_tdata[47:32];
            r_load <= s_axis_tdata[63:48];
            r_time <= s_axis_tdata[95:64];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_data <= {7'd0, load_next, dc_next, noise_next, total_next,
                           clip_next, peak_next, vu_next};
        end
    end

endmodule
